// ===== hw/rtl/pau_pkg.sv =====
// ============================================================================
// Pareto archive update package
// Shared types and fixed field widths for the bi-objective archive filter.
// ============================================================================
package pau_pkg;

    // Width of one cost value.
    localparam int COST_W = 32;

    // Width of the count fields on the result ports.
    localparam int CNT_OUT_W = 7;

    // Update sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== hw/rtl/pau_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ============================================================================
module pau_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pareto_archive_update.sv =====
// ============================================================================
// Pareto archive update
// Keeps an ordered archive of mutually non-dominated cost pairs in one RAM
// and filters each requested candidate against it in a single in-order pass.
// ============================================================================
// A request (start high while busy is low) offers one cost pair. The block
// streams the stored archive out of its RAM, one entry per cycle, and
// compacts the survivors in place behind the read pointer. The archive
// holds at most ARCHIVE_DEPTH entries. The scan stops early when a stored
// entry dominates the candidate. The single RAM read port limits the scan
// to one entry compared per cycle; a finishing step then appends the
// candidate if it survives and fits, and registers the result. The result
// is shown for exactly one cycle on o_valid, and the receiver cannot stall
// it, so it must take every result in that cycle. Busy is already low
// while the result is shown, so the next request may be accepted at the
// edge that ends the result cycle. The archive is empty after reset;
// no clearing pass is needed.
module pareto_archive_update
    import pau_pkg::*;
#(
    parameter int ARCHIVE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COST_W-1:0]    i_cost_a,
    input  logic [COST_W-1:0]    i_cost_b,
    output logic                 o_valid,
    output logic                 o_accepted,
    output logic [CNT_OUT_W-1:0] o_removed_count,
    output logic [CNT_OUT_W-1:0] o_archive_size,
    output logic                 o_overflow
);

    localparam int AW = $clog2(ARCHIVE_DEPTH);
    localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ARCHIVE_DEPTH);

    t_state r_state, n_state;

    logic [COST_W-1:0] r_cand_a, n_cand_a;
    logic [COST_W-1:0] r_cand_b, n_cand_b;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_proc, n_proc;
    logic [CW-1:0]     r_kept, n_kept;
    logic [CW-1:0]     r_removed, n_removed;
    logic              r_rej, n_rej;

    logic                 r_valid, n_valid;
    logic                 r_acc, n_acc;
    logic                 r_ovf, n_ovf;
    logic [CNT_OUT_W-1:0] r_rm_out, n_rm_out;
    logic [CNT_OUT_W-1:0] r_sz_out, n_sz_out;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [2*COST_W-1:0]   ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [2*COST_W-1:0]   ram_rdata;

    logic [COST_W-1:0] ent_a, ent_b;
    logic              ent_beats_cand;
    logic              cand_beats_ent;
    logic [CW-1:0]     proc_inc;

    // Archive storage: cost_a in the upper half, cost_b in the lower half.
    pau_ram #(
        .WIDTH (2 * COST_W),
        .DEPTH (ARCHIVE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Dominance tests between the entry just read and the candidate.
    assign ent_a          = ram_rdata[2*COST_W-1:COST_W];
    assign ent_b          = ram_rdata[COST_W-1:0];
    assign ent_beats_cand = (ent_a < r_cand_a) && (ent_b < r_cand_b);
    assign cand_beats_ent = (r_cand_a < ent_a) && (r_cand_b < ent_b);
    assign proc_inc       = r_proc + CW'(1);

    // State register and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_cand_a  <= n_cand_a;
        r_cand_b  <= n_cand_b;
        r_proc    <= n_proc;
        r_kept    <= n_kept;
        r_removed <= n_removed;
        r_rej     <= n_rej;
        r_acc     <= n_acc;
        r_ovf     <= n_ovf;
        r_rm_out  <= n_rm_out;
        r_sz_out  <= n_sz_out;
    end

    // Next state, RAM accesses and result formation.
    always_comb begin
        n_state   = r_state;
        n_cand_a  = r_cand_a;
        n_cand_b  = r_cand_b;
        n_count   = r_count;
        n_proc    = r_proc;
        n_kept    = r_kept;
        n_removed = r_removed;
        n_rej     = r_rej;
        n_valid   = 1'b0;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_rm_out  = r_rm_out;
        n_sz_out  = r_sz_out;
        ram_we    = 1'b0;
        ram_waddr = r_kept[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = proc_inc[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                // Entry 0 is read on the accepting edge.
                ram_raddr = '0;
                if (start) begin
                    n_cand_a  = i_cost_a;
                    n_cand_b  = i_cost_b;
                    n_proc    = '0;
                    n_kept    = '0;
                    n_removed = '0;
                    n_rej     = 1'b0;
                    n_state   = (r_count == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // One stored entry per cycle; survivors move down to the kept slot.
                if (ent_beats_cand) begin
                    n_rej   = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    if (cand_beats_ent) begin
                        n_removed = r_removed + CW'(1);
                    end else begin
                        ram_we = 1'b1;
                        n_kept = r_kept + CW'(1);
                    end
                    n_proc = proc_inc;
                    if (proc_inc == r_count) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                // Append the candidate if it was not dominated and there is room, and present the result.
                n_valid = 1'b1;
                n_state = ST_IDLE;
                ram_wdata = {r_cand_a, r_cand_b};
                if (r_rej) begin
                    n_acc    = 1'b0;
                    n_ovf    = 1'b0;
                    n_rm_out = '0;
                    n_sz_out = CNT_OUT_W'(r_count);
                end else if (r_kept < DEPTH_C) begin
                    ram_we   = 1'b1;
                    n_count  = r_kept + CW'(1);
                    n_acc    = 1'b1;
                    n_ovf    = 1'b0;
                    n_rm_out = CNT_OUT_W'(r_removed);
                    n_sz_out = CNT_OUT_W'(r_kept + CW'(1));
                end else begin
                    n_count  = r_kept;
                    n_acc    = 1'b0;
                    n_ovf    = 1'b1;
                    n_rm_out = CNT_OUT_W'(r_removed);
                    n_sz_out = CNT_OUT_W'(r_kept);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Port drives.
    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_accepted      = r_acc;
    assign o_overflow      = r_ovf;
    assign o_removed_count = r_rm_out;
    assign o_archive_size  = r_sz_out;

`ifndef NO_ASSERTIONS
    // Every scanned entry is either kept or removed.
    a_scan_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_kept + r_removed == r_proc))
        else $error("scan bookkeeping out of balance");

    // The archive never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds archive depth");

    // Every finishing step of an update is followed by a result.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |=> o_valid)
        else $error("result strobe missing after finish");

    // A candidate is never both accepted and dropped for overflow.
    a_acc_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_accepted && o_overflow))
        else $error("accepted and overflow both set");

    // An overflow result reports a full archive.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (r_count == DEPTH_C))
        else $error("overflow reported with free slots");
`endif

endmodule
